// ----- src/chacha20_block_keystream_assert.svh -----
// assertion macros for the chacha20 keystream block
// expects clk and rst_n in the scope where a macro is used
`ifndef CHACHA20_BLOCK_KEYSTREAM_ASSERT_SVH
`define CHACHA20_BLOCK_KEYSTREAM_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define CC20_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cc20 sequencing check failed");

// consequent must hold in the same cycle as the antecedent
`define CC20_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cc20 output check failed");

`endif

// ----- src/cc20_pkg.sv -----
// shared types, constants and the microcode rom for the chacha20 keystream block
// no dependencies
package cc20_pkg;

    localparam int WORD_W = 32;
    localparam int NWORDS = 16;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [2:0]        pc_t;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_KEY_LOW      = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY_MID_LOW  = 3'd1;
    localparam logic [IDX_W-1:0] REG_KEY_MID_HIGH = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEY_HIGH     = 3'd3;
    localparam logic [IDX_W-1:0] REG_NONCE_LOW    = 3'd4;
    localparam logic [IDX_W-1:0] REG_NONCE_HIGH   = 3'd5;

    localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

    localparam int ROT_A = 16;
    localparam int ROT_B = 12;
    localparam int ROT_C = 8;
    localparam int ROT_D = 7;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_ROUND,
        OP_EMIT
    } op_t;

    // program addresses
    localparam pc_t PC_WAIT   = 3'd0;
    localparam pc_t PC_COL0   = 3'd1;
    localparam pc_t PC_COL1   = 3'd2;
    localparam pc_t PC_DIAG0  = 3'd3;
    localparam pc_t PC_DIAG1  = 3'd4;
    localparam pc_t PC_EMIT   = 3'd5;

    typedef struct packed {
        op_t  op;
        logic diag;
        logic half;
        logic loop;
        pc_t  target;
    } ucode_t;

    // control handed from the sequencer to the datapath
    typedef struct packed {
        op_t  op;
        logic diag;
        logic half;
    } ctrl_t;

    // status handed from the datapath back to the sequencer
    typedef struct packed {
        logic in_fire;
        logic emit_done;
    } stat_t;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        begin
            case (pc)
                PC_WAIT:  w = '{op: OP_WAIT,  diag: 1'b0, half: 1'b0, loop: 1'b0, target: PC_COL0};
                PC_COL0:  w = '{op: OP_ROUND, diag: 1'b0, half: 1'b0, loop: 1'b0, target: PC_COL0};
                PC_COL1:  w = '{op: OP_ROUND, diag: 1'b0, half: 1'b1, loop: 1'b0, target: PC_COL0};
                PC_DIAG0: w = '{op: OP_ROUND, diag: 1'b1, half: 1'b0, loop: 1'b0, target: PC_COL0};
                PC_DIAG1: w = '{op: OP_ROUND, diag: 1'b1, half: 1'b1, loop: 1'b1, target: PC_COL0};
                PC_EMIT:  w = '{op: OP_EMIT,  diag: 1'b0, half: 1'b0, loop: 1'b0, target: PC_WAIT};
                default:  w = '{op: OP_WAIT,  diag: 1'b0, half: 1'b0, loop: 1'b0, target: PC_WAIT};
            endcase
            return w;
        end
    endfunction

    // state word used by lane (a, b, c, d) of quarter-round unit u
    function automatic logic [3:0] qr_index(input logic [1:0] u, input logic [1:0] lane,
                                            input logic diag);
        logic [1:0] col;
        begin
            col = diag ? 2'(u + lane) : u;
            return {lane, col};
        end
    endfunction

endpackage

// ----- src/cc20_qround.sv -----
// half of a chacha20 quarter-round: two add, xor, rotate steps
// depends on cc20_pkg
module cc20_qround (
    input  cc20_pkg::word_t a,
    input  cc20_pkg::word_t b,
    input  cc20_pkg::word_t c,
    input  cc20_pkg::word_t d,
    input  logic            half,
    output cc20_pkg::word_t a_out,
    output cc20_pkg::word_t b_out,
    output cc20_pkg::word_t c_out,
    output cc20_pkg::word_t d_out
);
    import cc20_pkg::*;

    word_t a_sum;
    word_t d_x;
    word_t c_sum;
    word_t b_x;

    always_comb
    begin
        a_sum = a + b;
        d_x   = d ^ a_sum;
        // first half rotates by 16 then 12, second half by 8 then 7
        if (half)
        begin
            d_out = {d_x[WORD_W-ROT_C-1:0], d_x[WORD_W-1:WORD_W-ROT_C]};
        end
        else
        begin
            d_out = {d_x[WORD_W-ROT_A-1:0], d_x[WORD_W-1:WORD_W-ROT_A]};
        end
        c_sum = c + d_out;
        b_x   = b ^ c_sum;
        if (half)
        begin
            b_out = {b_x[WORD_W-ROT_D-1:0], b_x[WORD_W-1:WORD_W-ROT_D]};
        end
        else
        begin
            b_out = {b_x[WORD_W-ROT_B-1:0], b_x[WORD_W-1:WORD_W-ROT_B]};
        end
        a_out = a_sum;
        c_out = c_sum;
    end

endmodule

// ----- src/cc20_seq.sv -----
// microcode sequencer: program counter, rom lookup and double-round counter
// depends on cc20_pkg
module cc20_seq #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cc20_pkg::stat_t stat,
    output cc20_pkg::ctrl_t ctrl
);
    import cc20_pkg::*;

    localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(DOUBLE_ROUNDS - 1);

    pc_t              pc_reg;
    pc_t              pc_next;
    logic [RND_W-1:0] rnd_reg;
    logic [RND_W-1:0] rnd_next;
    ucode_t           uw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_WAIT;
            rnd_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            rnd_reg <= rnd_next;
        end
    end

    always_comb
    begin
        uw       = ucode_rom(pc_reg);
        pc_next  = pc_reg;
        rnd_next = rnd_reg;
        case (uw.op)
            OP_WAIT:
            begin
                if (stat.in_fire)
                begin
                    pc_next  = uw.target;
                    rnd_next = '0;
                end
            end
            OP_ROUND:
            begin
                // loop back for the next double round until the last one is done
                if (uw.loop && (rnd_reg != RND_LAST))
                begin
                    pc_next  = uw.target;
                    rnd_next = rnd_reg + 1'b1;
                end
                else
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            OP_EMIT:
            begin
                if (stat.emit_done)
                begin
                    pc_next = uw.target;
                end
            end
            default:
            begin
                pc_next = PC_WAIT;
            end
        endcase
        ctrl.op   = uw.op;
        ctrl.diag = uw.diag;
        ctrl.half = uw.half;
    end

endmodule

// ----- src/chacha20_block_keystream.sv -----
// chacha20 block function top level: config registers, state words, output register
// depends on cc20_pkg, cc20_seq, cc20_qround and chacha20_block_keystream_assert.svh
//
//  channel | handshake           | payload
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//  in      | in_valid/in_stall   | block_counter
//  out     | out_valid/out_stall | word_index, keystream_word, last_word
//
// one block: the counter is taken, then DOUBLE_ROUNDS double rounds run on four
// half quarter-round units, one half quarter-round each per cycle, then 16 beats out
// of a single output register
// the next counter is taken as soon as the last word sits in the output register
// reset clears the config registers to zero and the sequencer to its wait step
`include "chacha20_block_keystream_assert.svh"

module chacha20_block_keystream #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cc20_pkg::IDX_W-1:0] cfg_index,
    input  logic [cc20_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  cc20_pkg::word_t           block_counter,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [3:0]                word_index,
    output cc20_pkg::word_t           keystream_word,
    output logic                      last_word
);
    import cc20_pkg::*;

    logic [CFG_W-1:0] key_low_reg;
    logic [CFG_W-1:0] key_mid_low_reg;
    logic [CFG_W-1:0] key_mid_high_reg;
    logic [CFG_W-1:0] key_high_reg;
    logic [CFG_W-1:0] nonce_low_reg;
    word_t            nonce_high_reg;

    word_t       counter_reg;
    word_t       state_reg [NWORDS];
    word_t       state_next [NWORDS];
    word_t       init_w [NWORDS];
    logic [3:0]  word_cnt_reg;
    logic        out_valid_reg;
    logic [3:0]  word_index_reg;
    word_t       keystream_word_reg;
    logic        last_word_reg;

    ctrl_t ctrl;
    stat_t stat;
    logic  in_fire;
    logic  load_out;
    logic  emit_done;

    word_t qa [4];
    word_t qb [4];
    word_t qc [4];
    word_t qd [4];
    word_t qa_o [4];
    word_t qb_o [4];
    word_t qc_o [4];
    word_t qd_o [4];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg      <= '0;
            key_mid_low_reg  <= '0;
            key_mid_high_reg <= '0;
            key_high_reg     <= '0;
            nonce_low_reg    <= '0;
            nonce_high_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_LOW:      key_low_reg      <= cfg_data;
                REG_KEY_MID_LOW:  key_mid_low_reg  <= cfg_data;
                REG_KEY_MID_HIGH: key_mid_high_reg <= cfg_data;
                REG_KEY_HIGH:     key_high_reg     <= cfg_data;
                REG_NONCE_LOW:    nonce_low_reg    <= cfg_data;
                REG_NONCE_HIGH:   nonce_high_reg   <= cfg_data[WORD_W-1:0];
                default:          ;
            endcase
        end
    end

    // initial state, counter word taken from the held counter
    always_comb
    begin
        init_w[0]  = SIGMA[0];
        init_w[1]  = SIGMA[1];
        init_w[2]  = SIGMA[2];
        init_w[3]  = SIGMA[3];
        init_w[4]  = key_low_reg[WORD_W-1:0];
        init_w[5]  = key_low_reg[CFG_W-1:WORD_W];
        init_w[6]  = key_mid_low_reg[WORD_W-1:0];
        init_w[7]  = key_mid_low_reg[CFG_W-1:WORD_W];
        init_w[8]  = key_mid_high_reg[WORD_W-1:0];
        init_w[9]  = key_mid_high_reg[CFG_W-1:WORD_W];
        init_w[10] = key_high_reg[WORD_W-1:0];
        init_w[11] = key_high_reg[CFG_W-1:WORD_W];
        init_w[12] = counter_reg;
        init_w[13] = nonce_low_reg[WORD_W-1:0];
        init_w[14] = nonce_low_reg[CFG_W-1:WORD_W];
        init_w[15] = nonce_high_reg;
    end

    assign in_stall  = (ctrl.op != OP_WAIT);
    assign in_fire   = in_valid && !in_stall;
    assign load_out  = (ctrl.op == OP_EMIT) && (!out_valid_reg || !out_stall);
    assign emit_done = load_out && (word_cnt_reg == 4'hf);

    assign stat.in_fire   = in_fire;
    assign stat.emit_done = emit_done;

    cc20_seq #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    for (genvar u = 0; u < 4; u++)
    begin : g_qr
        assign qa[u] = state_reg[qr_index(2'(u), 2'd0, ctrl.diag)];
        assign qb[u] = state_reg[qr_index(2'(u), 2'd1, ctrl.diag)];
        assign qc[u] = state_reg[qr_index(2'(u), 2'd2, ctrl.diag)];
        assign qd[u] = state_reg[qr_index(2'(u), 2'd3, ctrl.diag)];

        cc20_qround u_qr (
            .a     (qa[u]),
            .b     (qb[u]),
            .c     (qc[u]),
            .d     (qd[u]),
            .half  (ctrl.half),
            .a_out (qa_o[u]),
            .b_out (qb_o[u]),
            .c_out (qc_o[u]),
            .d_out (qd_o[u])
        );
    end

    always_comb
    begin
        for (int i = 0; i < NWORDS; i++)
        begin
            state_next[i] = state_reg[i];
        end
        if (in_fire)
        begin
            for (int i = 0; i < NWORDS; i++)
            begin
                state_next[i] = init_w[i];
            end
            state_next[12] = block_counter;
        end
        else if (ctrl.op == OP_ROUND)
        begin
            for (int u = 0; u < 4; u++)
            begin
                state_next[qr_index(2'(u), 2'd0, ctrl.diag)] = qa_o[u];
                state_next[qr_index(2'(u), 2'd1, ctrl.diag)] = qb_o[u];
                state_next[qr_index(2'(u), 2'd2, ctrl.diag)] = qc_o[u];
                state_next[qr_index(2'(u), 2'd3, ctrl.diag)] = qd_o[u];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NWORDS; i++)
        begin
            state_reg[i] <= state_next[i];
        end
        if (in_fire)
        begin
            counter_reg <= block_counter;
        end
        if (load_out)
        begin
            word_index_reg     <= word_cnt_reg;
            keystream_word_reg <= state_reg[word_cnt_reg] + init_w[word_cnt_reg];
            last_word_reg      <= (word_cnt_reg == 4'hf);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                word_cnt_reg <= '0;
            end
            else if (load_out)
            begin
                word_cnt_reg <= word_cnt_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign word_index     = word_index_reg;
    assign keystream_word = keystream_word_reg;
    assign last_word      = last_word_reg;

    `CC20_ASSERT_NEXT(a_done_to_wait, emit_done, !in_stall)
    `CC20_ASSERT_NEXT(a_fire_to_round, in_fire, (ctrl.op == OP_ROUND) && (word_cnt_reg == 4'h0))
    `CC20_ASSERT_NEXT(a_drain_clears, out_valid_reg && !out_stall && !load_out, !out_valid_reg)
    `CC20_ASSERT_SAME(a_last_index, out_valid_reg && last_word_reg, word_index_reg == 4'hf)

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the chacha20 keystream block: random and directed counters
// under several key/nonce settings, a scoreboard class predicts the 16 words per block
// depends on cc20_pkg and the chacha20_block_keystream rtl
module testbench;
    import cc20_pkg::*;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int IDLE_PCT      = 18;
    localparam int WATCHDOG_MAX  = 1000;
    localparam int DRAIN_CYCLES  = 70;

    // indexes past the last register, writes there must be ignored
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [3:0] idx;
        word_t      word;
        logic       last;
    } ks_beat_t;

    class keystream_scoreboard;
        word_t      key_w [8];
        word_t      nonce_w [3];
        word_t      mix_st [16];
        ks_beat_t   expected_q [$];
        int         errors;

        function new();
            foreach (key_w[i]) key_w[i] = '0;
            foreach (nonce_w[i]) nonce_w[i] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                REG_KEY_LOW:      begin key_w[0] = data[31:0]; key_w[1] = data[63:32]; end
                REG_KEY_MID_LOW:  begin key_w[2] = data[31:0]; key_w[3] = data[63:32]; end
                REG_KEY_MID_HIGH: begin key_w[4] = data[31:0]; key_w[5] = data[63:32]; end
                REG_KEY_HIGH:     begin key_w[6] = data[31:0]; key_w[7] = data[63:32]; end
                REG_NONCE_LOW:
                begin
                    nonce_w[0] = data[31:0];
                    nonce_w[1] = data[63:32];
                end
                REG_NONCE_HIGH:   nonce_w[2] = data[31:0];
                default: ;
            endcase
        endfunction

        function word_t rotl(word_t x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void quarter(int ia, int ib, int ic, int id);
            word_t a, b, c, d;
            a = mix_st[ia]; b = mix_st[ib]; c = mix_st[ic]; d = mix_st[id];
            a = a + b; d = rotl(d ^ a, 16);
            c = c + d; b = rotl(b ^ c, 12);
            a = a + b; d = rotl(d ^ a, 8);
            c = c + d; b = rotl(b ^ c, 7);
            mix_st[ia] = a; mix_st[ib] = b; mix_st[ic] = c; mix_st[id] = d;
        endfunction

        // one accepted counter: build the initial state, run the rounds, queue 16 words
        function void note_block(word_t counter);
            word_t    init_st [16];
            ks_beat_t beat;
            init_st[0] = 32'h61707865;
            init_st[1] = 32'h3320646e;
            init_st[2] = 32'h79622d32;
            init_st[3] = 32'h6b206574;
            for (int i = 0; i < 8; i++) init_st[4 + i] = key_w[i];
            init_st[12] = counter;
            for (int i = 0; i < 3; i++) init_st[13 + i] = nonce_w[i];
            mix_st = init_st;
            for (int r = 0; r < DOUBLE_ROUNDS; r++)
            begin
                for (int c = 0; c < 4; c++) quarter(c, 4 + c, 8 + c, 12 + c);
                for (int c = 0; c < 4; c++)
                    quarter(c, 4 + (c + 1) % 4, 8 + (c + 2) % 4, 12 + (c + 3) % 4);
            end
            for (int i = 0; i < 16; i++)
            begin
                beat.idx  = 4'(i);
                beat.word = mix_st[i] + init_st[i];
                beat.last = (i == 15);
                expected_q.insert(expected_q.size(), beat);
            end
        endfunction

        function void check_beat(logic [3:0] idx, word_t word, logic last);
            ks_beat_t exp_b;
            if (expected_q.size() == 0)
            begin
                $error("unexpected output beat: word_index %0d keystream_word %h", idx, word);
                errors++;
                return;
            end
            exp_b = expected_q.pop_front();
            if (idx !== exp_b.idx)
            begin
                $error("word_index: expected %0d, got %0d", exp_b.idx, idx);
                errors++;
            end
            if (word !== exp_b.word)
            begin
                $error("keystream_word: expected %h, got %h", exp_b.word, word);
                errors++;
            end
            if (last !== exp_b.last)
            begin
                $error("last_word: expected %0d, got %0d", exp_b.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    word_t              block_counter = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [3:0]         word_index;
    word_t              keystream_word;
    logic               last_word;

    keystream_scoreboard ks_sb = new();
    bit                  quiet = 1'b0;
    int                  stuck_cycles = 0;

    chacha20_block_keystream #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .block_counter  (block_counter),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_index     (word_index),
        .keystream_word (keystream_word),
        .last_word      (last_word)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // all handshakes are sampled with the values present at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready) ks_sb.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall) ks_sb.note_block(block_counter);
            if (out_valid && !out_stall) ks_sb.check_beat(word_index, keystream_word, last_word);
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_MAX)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // leaves cfg_valid high so back-to-back writes never toggle it within a step
    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_key(input logic [CFG_W-1:0] k0, input logic [CFG_W-1:0] k1,
                            input logic [CFG_W-1:0] k2, input logic [CFG_W-1:0] k3,
                            input logic [CFG_W-1:0] n0, input logic [CFG_W-1:0] n1);
        write_reg(REG_KEY_LOW, k0);
        write_reg(REG_KEY_MID_LOW, k1);
        write_reg(REG_KEY_MID_HIGH, k2);
        write_reg(REG_KEY_HIGH, k3);
        write_reg(REG_NONCE_LOW, n0);
        write_reg(REG_NONCE_HIGH, n1);
        if ($urandom_range(1)) write_reg(REG_SPARE_LO, {$urandom, $urandom});
        else write_reg(REG_SPARE_HI, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_block(input word_t counter);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        block_counter <= counter;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ks_sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_cfg();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic word_t pick_counter();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // key and nonce still at their reset value
        send_block(32'h0);
        send_block(32'hffff_ffff);
        drain();

        // well-known vector: key bytes 00..1f, nonce 00000009 0000004a 00000000
        load_key(64'h07060504_03020100, 64'h0f0e0d0c_0b0a0908,
                 64'h17161514_13121110, 64'h1f1e1d1c_1b1a1918,
                 64'h4a000000_09000000, 64'h0);
        send_block(32'h1);
        send_block(32'h0);
        drain();

        // all ones, nonce_high upper bits must be dropped
        load_key('1, '1, '1, '1, '1, '1);
        send_block(32'h0);
        send_block(32'h1);
        send_block(32'h7fff_ffff);
        send_block(32'h8000_0000);
        send_block(32'hffff_ffff);
        drain();

        load_key({2{32'haaaa_aaaa}}, {2{32'h5555_5555}}, {2{32'haaaa_aaaa}},
                 {2{32'h5555_5555}}, {2{32'haaaa_aaaa}}, {32'h5555_5555, 32'haaaa_aaaa});
        send_block(32'haaaa_aaaa);
        send_block(32'h5555_5555);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            quiet = (ph == 2);
            load_key(pick_cfg(), pick_cfg(), pick_cfg(), pick_cfg(), pick_cfg(), pick_cfg());
            for (int n = 0; n < 40; n++)
            begin
                send_block(pick_counter());
                // hold the sender off until every queued beat has come out
                if (ph == 4 && n == 19) drain();
            end
            drain();
        end
        quiet = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ks_sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- chacha20_block_keystream.f -----
+incdir+src
src/cc20_pkg.sv
src/cc20_qround.sv
src/cc20_seq.sv
src/chacha20_block_keystream.sv
tb/testbench.sv
